FILE: rtl/core/leg_geometric_jacobian_assert.svh
// Assertion macros shared by the leg Jacobian RTL.
// Depends on nothing; included by modules that carry concurrent checks.
`ifndef LEG_GEOMETRIC_JACOBIAN_ASSERT_SVH
`define LEG_GEOMETRIC_JACOBIAN_ASSERT_SVH

// Condition must hold at every clock edge out of reset.
`define LGJ_ASSERT_ALWAYS(lbl, ck, rn, cond) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (cond)) \
    else $error("lgj: invariant violated");

// Consequent must hold in the same cycle as the antecedent.
`define LGJ_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("lgj: implication violated");

// Consequent must hold in the cycle after the antecedent.
`define LGJ_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("lgj: next-cycle implication violated");

`endif

FILE: rtl/core/lgj_pkg.sv
// Shared types, constants and arithmetic helpers for the leg Jacobian block.
// Depends on nothing; imported by every module of the block but lgj_fifo.
`default_nettype none

package lgj_pkg;

  localparam int unsigned SIN_A = 102944;
  localparam int unsigned SIN_B = 42048;
  localparam int unsigned SIN_C = 4640;

  // Link lengths in micrometres, scaled to the length format at elaboration.
  localparam longint unsigned UM_HIP_X     = 64'd193400;
  localparam longint unsigned UM_HIP_Y     = 64'd46500;
  localparam longint unsigned UM_HIP_LEN   = 64'd95500;
  localparam longint unsigned UM_THIGH_LEN = 64'd213000;
  localparam longint unsigned UM_CALF_LEN  = 64'd213000;

  typedef enum logic [2:0] {
    REG_HIP_X     = 3'd0,
    REG_HIP_Y     = 3'd1,
    REG_HIP_LEN   = 3'd2,
    REG_THIGH_LEN = 3'd3,
    REG_CALF_LEN  = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    JOINT_HIP   = 2'd0,
    JOINT_THIGH = 2'd1,
    JOINT_CALF  = 2'd2
  } joint_t;

  typedef logic signed [15:0] trig_t;
  typedef logic signed [17:0] lin_t;
  typedef logic signed [47:0] acc_t;

  localparam trig_t ONE_Q14 = 16'sd16384;

  typedef struct packed {
    logic [1:0] leg_out;
    joint_t     joint;
    lin_t       lin_x;
    lin_t       lin_y;
    lin_t       lin_z;
    trig_t      ang_x;
    trig_t      ang_y;
    trig_t      ang_z;
    logic       last;
  } col_t;

  typedef struct packed {
    logic [15:0] hip_len;
    logic [15:0] thigh_len;
    logic [15:0] calf_len;
  } link_cfg_t;

  function automatic acc_t rnd14(acc_t x);
    return (x + acc_t'(8192)) >>> 14;
  endfunction

  function automatic lin_t sat_lin(acc_t x);
    lin_t res;
    if (x > acc_t'(131071)) begin
      res = 18'sh1FFFF;
    end else if (x < acc_t'(-131072)) begin
      res = 18'sh20000;
    end else begin
      res = x[17:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/leg_geometric_jacobian.sv
// Top level of the leg geometric Jacobian block: register file, front end,
// queue and back end. Depends on lgj_pkg, lgj_front, lgj_fifo, lgj_back.
//
//   channel | handshake              | carries
//   --------+------------------------+------------------------------------------
//   in      | in_valid / in_ready    | leg index, hip/thigh/calf binary angles
//   out     | out_valid / out_ready  | one Jacobian column per beat, 3 per item
//   cfg     | psel/penable/pwrite    | link length registers, APB-style
//
// An item holds the shared issue slot for one phase per angle (hip, thigh, calf)
// through the paired sine/cosine pipelines; the back end pops a new item only
// when the slot is idle or on the last item's calf phase and credits allow.
// rst_n is synchronous: it clears queue, sequencer, credits; reloads registers.
// The output side stalls independently: a 32-column buffer with credit
// tracking holds results, and a 2-deep queue decouples the input side.
`default_nettype none

module leg_geometric_jacobian #(
  parameter int ANGLE_BITS       = 16,
  parameter int LENGTH_FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,

  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_leg,
  input  logic signed [15:0] in_angle_hip,
  input  logic signed [15:0] in_angle_thigh,
  input  logic signed [15:0] in_angle_calf,

  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_leg_out,
  output logic [1:0]         out_joint,
  output logic signed [17:0] out_lin_x,
  output logic signed [17:0] out_lin_y,
  output logic signed [17:0] out_lin_z,
  output logic signed [15:0] out_ang_x,
  output logic signed [15:0] out_ang_y,
  output logic signed [15:0] out_ang_z,
  output logic               out_last,

  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import lgj_pkg::*;

  localparam int IW = 2 + 3 * ANGLE_BITS;

  // Reset lengths: round micrometres into the length format, cap at 16 bits.
  localparam longint unsigned RAW_HX =
    ((UM_HIP_X << LENGTH_FRAC_BITS) + 64'd500000) / 64'd1000000;
  localparam longint unsigned RAW_HY =
    ((UM_HIP_Y << LENGTH_FRAC_BITS) + 64'd500000) / 64'd1000000;
  localparam longint unsigned RAW_HL =
    ((UM_HIP_LEN << LENGTH_FRAC_BITS) + 64'd500000) / 64'd1000000;
  localparam longint unsigned RAW_TL =
    ((UM_THIGH_LEN << LENGTH_FRAC_BITS) + 64'd500000) / 64'd1000000;
  localparam longint unsigned RAW_CL =
    ((UM_CALF_LEN << LENGTH_FRAC_BITS) + 64'd500000) / 64'd1000000;

  localparam logic [15:0] RST_HX = (RAW_HX > 64'd65535) ? 16'hFFFF : RAW_HX[15:0];
  localparam logic [15:0] RST_HY = (RAW_HY > 64'd65535) ? 16'hFFFF : RAW_HY[15:0];
  localparam logic [15:0] RST_HL = (RAW_HL > 64'd65535) ? 16'hFFFF : RAW_HL[15:0];
  localparam logic [15:0] RST_TL = (RAW_TL > 64'd65535) ? 16'hFFFF : RAW_TL[15:0];
  localparam logic [15:0] RST_CL = (RAW_CL > 64'd65535) ? 16'hFFFF : RAW_CL[15:0];

  // Register file. Hip offsets cancel out of every column; keep them readable.
  logic [15:0] hip_x_r, hip_y_r, hip_len_r, thigh_len_r, calf_len_r;
  logic        wr_en;
  logic [2:0]  reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hip_x_r     <= RST_HX;
      hip_y_r     <= RST_HY;
      hip_len_r   <= RST_HL;
      thigh_len_r <= RST_TL;
      calf_len_r  <= RST_CL;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_HIP_X:     hip_x_r     <= pwdata[15:0];
        REG_HIP_Y:     hip_y_r     <= pwdata[15:0];
        REG_HIP_LEN:   hip_len_r   <= pwdata[15:0];
        REG_THIGH_LEN: thigh_len_r <= pwdata[15:0];
        REG_CALF_LEN:  calf_len_r  <= pwdata[15:0];
        default: ;  // drop writes past the last register
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_HIP_X:     prdata = {16'b0, hip_x_r};
      REG_HIP_Y:     prdata = {16'b0, hip_y_r};
      REG_HIP_LEN:   prdata = {16'b0, hip_len_r};
      REG_THIGH_LEN: prdata = {16'b0, thigh_len_r};
      REG_CALF_LEN:  prdata = {16'b0, calf_len_r};
      default:       prdata = '0;
    endcase
  end

  link_cfg_t links;
  assign links.hip_len   = hip_len_r;
  assign links.thigh_len = thigh_len_r;
  assign links.calf_len  = calf_len_r;

  // Front end and the queue that decouples it from the back end
  logic          q_full, q_push, q_empty, q_pop;
  logic [IW-1:0] q_wdata, q_rdata;

  lgj_front #(.ANGLE_BITS(ANGLE_BITS)) u_front (
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_leg         (in_leg),
    .in_angle_hip   (in_angle_hip),
    .in_angle_thigh (in_angle_thigh),
    .in_angle_calf  (in_angle_calf),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_data         (q_wdata)
  );

  lgj_fifo #(.WIDTH(IW), .DEPTH(2)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  // Back end: trig, products, column serializer and result buffer
  col_t out_col;

  lgj_back #(.ANGLE_BITS(ANGLE_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (!q_empty),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .links     (links),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_col   (out_col)
  );

  assign out_leg_out = out_col.leg_out;
  assign out_joint   = out_col.joint;
  assign out_lin_x   = out_col.lin_x;
  assign out_lin_y   = out_col.lin_y;
  assign out_lin_z   = out_col.lin_z;
  assign out_ang_x   = out_col.ang_x;
  assign out_ang_y   = out_col.ang_y;
  assign out_ang_z   = out_col.ang_z;
  assign out_last    = out_col.last;

endmodule

`default_nettype wire

FILE: rtl/core/lgj_fifo.sv
// Small synchronous FIFO with combinational head read.
// Depends on nothing; used as the front/back queue and the result buffer.
`default_nettype none

module lgj_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr_r;
  logic [AW-1:0]    rd_ptr_r;
  logic [CW-1:0]    count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + AW'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + AW'(1);
      case ({push, pop})
        2'b10:   count_r <= count_r + CW'(1);
        2'b01:   count_r <= count_r - CW'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= wdata;
  end

  assign rdata = mem[rd_ptr_r];
  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);

endmodule

`default_nettype wire

FILE: rtl/core/lgj_front.sv
// Front end: accepts input items, aligns the binary angles and forms the
// hip, thigh and thigh+calf phases. Depends on lgj_pkg.
`default_nettype none

module lgj_front #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                in_leg,
  input  logic signed [15:0]        in_angle_hip,
  input  logic signed [15:0]        in_angle_thigh,
  input  logic signed [15:0]        in_angle_calf,
  input  logic                      q_full,
  output logic                      q_push,
  output logic [2+3*ANGLE_BITS-1:0] q_data
);
  import lgj_pkg::*;

  localparam int AB = ANGLE_BITS;
  localparam logic [AB-1:0] QUARTER = AB'(1) << (AB - 2);

  logic [AB+15:0] hip_ext;
  logic [AB+15:0] thigh_ext;
  logic [AB+15:0] calf_ext;
  logic [AB-1:0]  p1;
  logic [AB-1:0]  p2;
  logic [AB-1:0]  p23;

  // Align 16-bit angles to the internal angle width.
  assign hip_ext   = {in_angle_hip,   {AB{1'b0}}};
  assign thigh_ext = {in_angle_thigh, {AB{1'b0}}};
  assign calf_ext  = {in_angle_calf,  {AB{1'b0}}};

  // Hip theta carries the fixed quarter-turn rotation.
  assign p1  = hip_ext[AB+15:16] + QUARTER;
  assign p2  = thigh_ext[AB+15:16];
  assign p23 = thigh_ext[AB+15:16] + calf_ext[AB+15:16];

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;
  assign q_data   = {in_leg, p1, p2, p23};

endmodule

`default_nettype wire

FILE: rtl/core/lgj_sine.sv
// Pipelined fixed-point sine, five register stages, Q1.14 output.
// Depends on lgj_pkg for the polynomial constants.
`default_nettype none

module lgj_sine #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                  clk,
  input  logic [ANGLE_BITS-1:0] phase,
  output lgj_pkg::trig_t        sin_q14
);
  import lgj_pkg::*;

  localparam int QB = ANGLE_BITS - 2;

  logic [QB+15:0] frac_ext;
  logic [16:0]    z0;

  logic [16:0] z1_r;
  logic [1:0]  quad1_r;
  logic [16:0] z2_r;
  logic [16:0] zsq2_r;
  logic [1:0]  quad2_r;
  logic [16:0] z3_r;
  logic [16:0] zsq3_r;
  logic [15:0] t1_r;
  logic [1:0]  quad3_r;
  logic [16:0] z4_r;
  logic [16:0] t2_r;
  logic [1:0]  quad4_r;
  trig_t       out_r;

  logic [33:0] zz;
  logic [29:0] cz;
  logic [33:0] tz;
  logic [34:0] sz;
  logic [18:0] s_rnd;
  logic [16:0] mag;
  logic [16:0] mag_cap;

  // Quarter-turn fraction in Q16, mirrored on odd quadrants.
  assign frac_ext = {phase[QB-1:0], 16'b0};
  assign z0 = phase[QB] ? (17'd65536 - {1'b0, frac_ext[QB+15:QB]})
                        : {1'b0, frac_ext[QB+15:QB]};

  assign zz    = 34'(z1_r) * 34'(z1_r) + 34'd32768;
  assign cz    = 30'(SIN_C) * 30'(zsq2_r) + 30'd32768;
  assign tz    = 34'(t1_r) * 34'(zsq3_r) + 34'd32768;
  assign sz    = 35'(t2_r) * 35'(z4_r) + 35'd32768;
  assign s_rnd = sz[34:16] + 19'd2;
  assign mag   = s_rnd[18:2];
  assign mag_cap = (mag > 17'd16384) ? 17'd16384 : mag;

  always_ff @(posedge clk) begin
    z1_r    <= z0;
    quad1_r <= phase[ANGLE_BITS-1:QB];

    z2_r    <= z1_r;
    zsq2_r  <= zz[32:16];
    quad2_r <= quad1_r;

    z3_r    <= z2_r;
    zsq3_r  <= zsq2_r;
    t1_r    <= 16'(SIN_B) - {2'b0, cz[29:16]};
    quad3_r <= quad2_r;

    z4_r    <= z3_r;
    t2_r    <= 17'(SIN_A) - 17'(tz[33:16]);
    quad4_r <= quad3_r;

    out_r   <= quad4_r[1] ? -trig_t'(mag_cap[15:0]) : trig_t'(mag_cap[15:0]);
  end

  assign sin_q14 = out_r;

endmodule

`default_nettype wire

FILE: rtl/core/lgj_back.sv
// Back end: issues angles to the sine units, forms the Jacobian columns and
// buffers them for the output channel. Depends on lgj_pkg, lgj_sine, lgj_fifo.
`default_nettype none

module lgj_back #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_valid,
  input  logic [2+3*ANGLE_BITS-1:0] q_data,
  output logic                      q_pop,
  input  lgj_pkg::link_cfg_t        links,
  output logic                      out_valid,
  input  logic                      out_ready,
  output lgj_pkg::col_t             out_col
);
  import lgj_pkg::*;
  `include "leg_geometric_jacobian_assert.svh"

  localparam int AB        = ANGLE_BITS;
  localparam int IW        = 2 + 3 * AB;
  localparam int LAT       = 5;
  localparam int OUT_DEPTH = 32;
  localparam int CW        = $clog2(OUT_DEPTH + 1);
  localparam logic [AB-1:0] QUARTER = AB'(1) << (AB - 2);

  // Issue sequencer
  logic [IW-1:0] item_r;
  logic          iss_v_r, iss_v_nxt;
  joint_t        iss_ph_r, iss_ph_nxt;
  logic [CW-1:0] credit_r, credit_nxt;
  logic [AB-1:0] sin_ang;
  logic [AB-1:0] cos_ang;
  trig_t         sin_q;
  trig_t         cos_q;
  logic          out_pop;

  assign q_pop = q_valid && (credit_r <= CW'(OUT_DEPTH - 3))
                 && (!iss_v_r || iss_ph_r == JOINT_CALF);
  assign out_pop = out_valid && out_ready;

  always_comb begin
    iss_v_nxt  = iss_v_r;
    iss_ph_nxt = iss_ph_r;
    if (q_pop) begin
      iss_v_nxt  = 1'b1;
      iss_ph_nxt = JOINT_HIP;
    end else if (iss_v_r) begin
      unique case (iss_ph_r)
        JOINT_HIP:   iss_ph_nxt = JOINT_THIGH;
        JOINT_THIGH: iss_ph_nxt = JOINT_CALF;
        default:     iss_v_nxt  = 1'b0;
      endcase
    end
  end

  always_comb begin
    credit_nxt = credit_r;
    if (q_pop)   credit_nxt = credit_nxt + CW'(3);
    if (out_pop) credit_nxt = credit_nxt - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_v_r  <= 1'b0;
      iss_ph_r <= JOINT_HIP;
      credit_r <= '0;
    end else begin
      iss_v_r  <= iss_v_nxt;
      iss_ph_r <= iss_ph_nxt;
      credit_r <= credit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) item_r <= q_data;
  end

  always_comb begin
    case (iss_ph_r)
      JOINT_HIP:   sin_ang = item_r[3*AB-1:2*AB];
      JOINT_THIGH: sin_ang = item_r[2*AB-1:AB];
      default:     sin_ang = item_r[AB-1:0];
    endcase
  end
  assign cos_ang = sin_ang + QUARTER;

  lgj_sine #(.ANGLE_BITS(AB)) u_sin (.clk(clk), .phase(sin_ang), .sin_q14(sin_q));
  lgj_sine #(.ANGLE_BITS(AB)) u_cos (.clk(clk), .phase(cos_ang), .sin_q14(cos_q));

  // Tags travel alongside the sine pipeline
  logic       tag_v_r   [LAT];
  joint_t     tag_ph_r  [LAT];
  logic [1:0] tag_leg_r [LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT; i++) tag_v_r[i] <= 1'b0;
    end else begin
      tag_v_r[0] <= iss_v_r;
      for (int i = 1; i < LAT; i++) tag_v_r[i] <= tag_v_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    tag_ph_r[0]  <= iss_ph_r;
    tag_leg_r[0] <= item_r[IW-1:IW-2];
    for (int i = 1; i < LAT; i++) begin
      tag_ph_r[i]  <= tag_ph_r[i-1];
      tag_leg_r[i] <= tag_leg_r[i-1];
    end
  end

  // Collect trig values of the current item
  trig_t      s1_r, c1_r, s2_r, c2_r;
  logic       fire_a;
  logic [1:0] leg_t;
  acc_t       a_s, a2_s, a3_s;

  assign fire_a = tag_v_r[LAT-1] && (tag_ph_r[LAT-1] == JOINT_CALF);
  assign leg_t  = tag_leg_r[LAT-1];

  always_ff @(posedge clk) begin
    if (tag_v_r[LAT-1] && tag_ph_r[LAT-1] == JOINT_HIP) begin
      s1_r <= sin_q;
      c1_r <= cos_q;
    end
    if (tag_v_r[LAT-1] && tag_ph_r[LAT-1] == JOINT_THIGH) begin
      s2_r <= sin_q;
      c2_r <= cos_q;
    end
  end

  // Left legs mirror the link signs
  always_comb begin
    a_s  = acc_t'({1'b0, links.hip_len});
    a2_s = acc_t'({1'b0, links.thigh_len});
    a3_s = acc_t'({1'b0, links.calf_len});
    if (!leg_t[0]) begin
      a_s  = -a_s;
      a2_s = -a2_s;
      a3_s = -a3_s;
    end
  end

  // Stage A: link-by-trig products
  logic       va_r, vb_r, vc_r, vd_r;
  acc_t       ma1_r, ma2_r, ma3_r, ma4_r, aa_r;
  trig_t      s1a_r, c1a_r, s1b_r, c1b_r, s1c_r, c1c_r, s1d_r, c1d_r;
  logic [1:0] lega_r, legb_r, legc_r, legd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else begin
      va_r <= fire_a;
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    ma1_r  <= a2_s * acc_t'(s2_r);
    ma2_r  <= a3_s * acc_t'(sin_q);
    ma3_r  <= a2_s * acc_t'(c2_r);
    ma4_r  <= a3_s * acc_t'(cos_q);
    aa_r   <= a_s;
    s1a_r  <= s1_r;
    c1a_r  <= c1_r;
    lega_r <= leg_t;
  end

  // Stage B: rounded sums
  acc_t pp_r, r2_r, q3_r, w3_r, rr_r;
  acc_t r2_b;

  assign r2_b = rnd14(ma3_r + ma4_r);

  always_ff @(posedge clk) begin
    pp_r   <= rnd14(ma1_r + ma2_r);
    r2_r   <= r2_b;
    q3_r   <= rnd14(ma2_r);
    w3_r   <= rnd14(ma4_r);
    rr_r   <= aa_r + r2_b;
    s1b_r  <= s1a_r;
    c1b_r  <= c1a_r;
    legb_r <= lega_r;
  end

  // Stage C: joint-to-foot vectors rotated by the hip angle
  acc_t dyh_r, dzh_r, dyt_r, dzt_r, dyc_r, dzc_r, ppc_r, q3c_r;

  always_ff @(posedge clk) begin
    dyh_r  <= rnd14(acc_t'(c1b_r) * rr_r);
    dzh_r  <= rnd14(acc_t'(s1b_r) * rr_r);
    dyt_r  <= rnd14(acc_t'(c1b_r) * r2_r);
    dzt_r  <= rnd14(acc_t'(s1b_r) * r2_r);
    dyc_r  <= rnd14(acc_t'(c1b_r) * w3_r);
    dzc_r  <= rnd14(acc_t'(s1b_r) * w3_r);
    ppc_r  <= pp_r;
    q3c_r  <= q3_r;
    s1c_r  <= s1b_r;
    c1c_r  <= c1b_r;
    legc_r <= legb_r;
  end

  // Stage D: cross-product terms
  acc_t lhy_r, lhz_r;
  acc_t xt1_r, xt2_r, yt_r, zt_r, xc1_r, xc2_r, yc_r, zc_r;

  always_ff @(posedge clk) begin
    lhy_r  <= -dzh_r;
    lhz_r  <= dyh_r;
    xt1_r  <= acc_t'(s1c_r) * dzt_r;
    xt2_r  <= acc_t'(c1c_r) * dyt_r;
    yt_r   <= acc_t'(c1c_r) * ppc_r;
    zt_r   <= acc_t'(s1c_r) * ppc_r;
    xc1_r  <= acc_t'(s1c_r) * dzc_r;
    xc2_r  <= acc_t'(c1c_r) * dyc_r;
    yc_r   <= acc_t'(c1c_r) * q3c_r;
    zc_r   <= acc_t'(s1c_r) * q3c_r;
    s1d_r  <= s1c_r;
    c1d_r  <= c1c_r;
    legd_r <= legc_r;
  end

  // Stage E: round, saturate, and load the column serializer
  col_t       cols [3];
  col_t       ser_r [3];
  logic       ser_v_r;
  logic [1:0] ser_idx_r;

  always_comb begin
    cols[0].leg_out = legd_r;
    cols[0].joint   = JOINT_HIP;
    cols[0].lin_x   = '0;
    cols[0].lin_y   = sat_lin(lhy_r);
    cols[0].lin_z   = sat_lin(lhz_r);
    cols[0].ang_x   = ONE_Q14;
    cols[0].ang_y   = '0;
    cols[0].ang_z   = '0;
    cols[0].last    = 1'b0;

    cols[1].leg_out = legd_r;
    cols[1].joint   = JOINT_THIGH;
    cols[1].lin_x   = sat_lin(rnd14(xt1_r + xt2_r));
    cols[1].lin_y   = sat_lin(rnd14(-yt_r));
    cols[1].lin_z   = sat_lin(rnd14(-zt_r));
    cols[1].ang_x   = '0;
    cols[1].ang_y   = s1d_r;
    cols[1].ang_z   = -c1d_r;
    cols[1].last    = 1'b0;

    cols[2].leg_out = legd_r;
    cols[2].joint   = JOINT_CALF;
    cols[2].lin_x   = sat_lin(rnd14(xc1_r + xc2_r));
    cols[2].lin_y   = sat_lin(rnd14(-yc_r));
    cols[2].lin_z   = sat_lin(rnd14(-zc_r));
    cols[2].ang_x   = '0;
    cols[2].ang_y   = s1d_r;
    cols[2].ang_z   = -c1d_r;
    cols[2].last    = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_v_r   <= 1'b0;
      ser_idx_r <= '0;
    end else if (vd_r) begin
      ser_v_r   <= 1'b1;
      ser_idx_r <= '0;
    end else if (ser_v_r) begin
      if (ser_idx_r == 2'd2) ser_v_r <= 1'b0;
      ser_idx_r <= ser_idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (vd_r) begin
      for (int i = 0; i < 3; i++) ser_r[i] <= cols[i];
    end
  end

  // Result buffer; credits keep it from overflowing
  logic                 of_full;
  logic                 of_empty;
  logic [$bits(col_t)-1:0] of_rdata;

  lgj_fifo #(.WIDTH($bits(col_t)), .DEPTH(OUT_DEPTH)) u_out_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (ser_v_r),
    .wdata (ser_r[ser_idx_r]),
    .full  (of_full),
    .pop   (out_pop),
    .rdata (of_rdata),
    .empty (of_empty)
  );

  assign out_valid = !of_empty;
  assign out_col   = col_t'(of_rdata);

  `LGJ_ASSERT_ALWAYS(a_credit_bound, clk, rst_n, credit_r <= CW'(OUT_DEPTH))
  `LGJ_ASSERT_IMPL(a_no_push_full, clk, rst_n, ser_v_r, !of_full)
  `LGJ_ASSERT_IMPL(a_ser_free, clk, rst_n, vd_r, !ser_v_r || ser_idx_r == 2'd2)
  `LGJ_ASSERT_NEXT(a_pop_issues_hip, clk, rst_n, q_pop,
                   iss_v_r && iss_ph_r == JOINT_HIP)

endmodule

`default_nettype wire

FILE: verif/leg_geometric_jacobian_tb.sv
// Self-checking bench for leg_geometric_jacobian: drives leg/angle beats and APB
// writes, predicts the three Jacobian columns per item and checks every column.
// Depends on lgj_pkg and the leg_geometric_jacobian RTL.
`default_nettype none

module leg_geometric_jacobian_tb;
  import lgj_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Indexes beyond the register file; writes there must be dropped.
  localparam logic [2:0] REG_SPARE_LO = 3'd5;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;
  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 40;

  // Column predictor plus the queue of columns still owed by the block.
  class jac_column_board;
    logic [15:0] len_hip, len_thigh, len_calf, off_x, off_y;
    col_t        owed_cols[$];
    int          mismatches;

    function new();
      // Reset values at 16 fractional length bits.
      off_x = 16'd12675;
      off_y = 16'd3047;
      len_hip = 16'd6259;
      len_thigh = 16'd13959;
      len_calf = 16'd13959;
      mismatches = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] value);
      case (idx)
        REG_HIP_X: off_x = value[15:0];
        REG_HIP_Y: off_y = value[15:0];
        REG_HIP_LEN: len_hip = value[15:0];
        REG_THIGH_LEN: len_thigh = value[15:0];
        REG_CALF_LEN: len_calf = value[15:0];
        default: ;
      endcase
    endfunction

    // Polynomial sine in Q1.14 of a 16-bit binary angle.
    function longint sine_q14(longint unsigned p);
      longint unsigned quad, z, z2, t, s, mag;
      quad = (p >> 14) & 3;
      z = (p & 64'h3FFF) << 2;
      if (quad[0]) begin
        z = 65536 - z;
      end
      z2 = (z * z + 32768) >> 16;
      t = SIN_B - ((SIN_C * z2 + 32768) >> 16);
      t = SIN_A - ((t * z2 + 32768) >> 16);
      s = (t * z + 32768) >> 16;
      mag = (s + 2) >> 2;
      if (mag > 16384) begin
        mag = 16384;
      end
      return quad[1] ? -longint'(mag) : longint'(mag);
    endfunction

    function longint cosine_q14(longint unsigned p);
      return sine_q14((p + 16384) & 64'hFFFF);
    endfunction

    function longint rnd_q14(longint x);
      return (x + 8192) >>> 14;
    endfunction

    function lin_t clamp_lin(longint v);
      if (v > 131071) begin
        v = 131071;
      end
      if (v < -131072) begin
        v = -131072;
      end
      return lin_t'(v);
    endfunction

    function col_t make_col(logic [1:0] leg, joint_t jnt, longint ax[3], longint d[3]);
      col_t c;
      c.leg_out = leg;
      c.joint = jnt;
      c.lin_x = clamp_lin(rnd_q14(ax[1] * d[2] - ax[2] * d[1]));
      c.lin_y = clamp_lin(rnd_q14(ax[2] * d[0] - ax[0] * d[2]));
      c.lin_z = clamp_lin(rnd_q14(ax[0] * d[1] - ax[1] * d[0]));
      c.ang_x = trig_t'(ax[0]);
      c.ang_y = trig_t'(ax[1]);
      c.ang_z = trig_t'(ax[2]);
      c.last = (jnt == JOINT_CALF);
      return c;
    endfunction

    // Queue the hip, thigh and calf columns for one accepted beat.
    function void predict_columns(logic [1:0] leg, logic [15:0] hip, logic [15:0] thigh,
                                  logic [15:0] calf);
      longint unsigned p1, p2, p23;
      longint k, a, a2, a3, s1, c1, s2, c2, s23, c23, pp, r2, rr, q3, w3;
      longint ax_hip[3], ax_leg[3], d_hip[3], d_thigh[3], d_calf[3];
      p1 = (longint'(hip) + 16384) & 64'hFFFF;
      p2 = longint'(thigh);
      p23 = (p2 + longint'(calf)) & 64'hFFFF;
      k = leg[0] ? 1 : -1;
      a = k * longint'(len_hip);
      a2 = k * longint'(len_thigh);
      a3 = k * longint'(len_calf);
      s1 = sine_q14(p1);
      c1 = cosine_q14(p1);
      s2 = sine_q14(p2);
      c2 = cosine_q14(p2);
      s23 = sine_q14(p23);
      c23 = cosine_q14(p23);
      pp = rnd_q14(a2 * s2 + a3 * s23);
      r2 = rnd_q14(a2 * c2 + a3 * c23);
      rr = a + r2;
      q3 = rnd_q14(a3 * s23);
      w3 = rnd_q14(a3 * c23);
      ax_hip = '{16384, 0, 0};
      ax_leg = '{0, s1, -c1};
      d_hip = '{pp, rnd_q14(c1 * rr), rnd_q14(s1 * rr)};
      d_thigh = '{pp, rnd_q14(c1 * r2), rnd_q14(s1 * r2)};
      d_calf = '{q3, rnd_q14(c1 * w3), rnd_q14(s1 * w3)};
      owed_cols.push_back(make_col(leg, JOINT_HIP, ax_hip, d_hip));
      owed_cols.push_back(make_col(leg, JOINT_THIGH, ax_leg, d_thigh));
      owed_cols.push_back(make_col(leg, JOINT_CALF, ax_leg, d_calf));
    endfunction

    function void check_column(col_t got);
      col_t want;
      if (owed_cols.size() == 0) begin
        $display("%0t: unexpected column leg %0d joint %0d", $time, got.leg_out, got.joint);
        mismatches++;
        return;
      end
      want = owed_cols.pop_front();
      if (got !== want) begin
        $display("%0t: column mismatch", $time);
        $display("  expected leg %0d joint %0d lin %0d %0d %0d ang %0d %0d %0d last %0d",
                 want.leg_out, want.joint, want.lin_x, want.lin_y, want.lin_z,
                 want.ang_x, want.ang_y, want.ang_z, want.last);
        $display("  actual   leg %0d joint %0d lin %0d %0d %0d ang %0d %0d %0d last %0d",
                 got.leg_out, got.joint, got.lin_x, got.lin_y, got.lin_z,
                 got.ang_x, got.ang_y, got.ang_z, got.last);
        mismatches++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_leg = '0;
  logic signed [15:0] in_angle_hip = '0;
  logic signed [15:0] in_angle_thigh = '0;
  logic signed [15:0] in_angle_calf = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         out_leg_out;
  logic [1:0]         out_joint;
  logic signed [17:0] out_lin_x, out_lin_y, out_lin_z;
  logic signed [15:0] out_ang_x, out_ang_y, out_ang_z;
  logic               out_last;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [4:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  jac_column_board board;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int quiet_cycles = 0;

  leg_geometric_jacobian DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_leg(in_leg),
    .in_angle_hip(in_angle_hip), .in_angle_thigh(in_angle_thigh),
    .in_angle_calf(in_angle_calf),
    .out_valid(out_valid), .out_ready(out_ready), .out_leg_out(out_leg_out),
    .out_joint(out_joint), .out_lin_x(out_lin_x), .out_lin_y(out_lin_y),
    .out_lin_z(out_lin_z), .out_ang_x(out_ang_x), .out_ang_y(out_ang_y),
    .out_ang_z(out_ang_z), .out_last(out_last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: stall out_ready at the current idle rate.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Monitor: note accepted beats, check returned columns, watch for a hang.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        board.predict_columns(in_leg, in_angle_hip, in_angle_thigh, in_angle_calf);
      end
      if (out_valid && out_ready) begin
        board.check_column('{out_leg_out, joint_t'(out_joint), out_lin_x, out_lin_y,
                             out_lin_z, out_ang_x, out_ang_y, out_ang_z, out_last});
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Send one beat; hold valid high across back-to-back beats, drop it only in gaps.
  task automatic send_leg(logic [1:0] leg, logic [15:0] hip, logic [15:0] thigh,
                          logic [15:0] calf);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_leg <= leg;
    in_angle_hip <= hip;
    in_angle_thigh <= thigh;
    in_angle_calf <= calf;
    do @(posedge clk); while (!in_ready);
  endtask

  // Pick an angle: mostly uniform, sometimes a turn boundary.
  function automatic logic [15:0] pick_angle();
    logic [15:0] marks[8] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
                              16'h7FFF, 16'hFFFF, 16'h3FFF, 16'h0001};
    if ($urandom_range(3) == 0) begin
      return marks[$urandom_range(7)];
    end
    return 16'($urandom_range(16'hFFFF));
  endfunction

  task automatic send_random(int count);
    repeat (count) begin
      send_leg(2'($urandom_range(3)), pick_angle(), pick_angle(), pick_angle());
    end
  endtask

  // Wait until every owed column is back, then let the pipeline settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.owed_cols.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // APB write: setup, then access; the register takes the value at the access edge.
  task automatic apb_write(logic [2:0] idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    board.write_reg(idx, value);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Write the whole register file; upper data bits carry junk that must be dropped.
  task automatic load_links(logic [15:0] hx, logic [15:0] hy, logic [15:0] hl,
                            logic [15:0] tl, logic [15:0] cl);
    apb_write(REG_HIP_X, {16'($urandom_range(16'hFFFF)), hx});
    apb_write(REG_HIP_Y, {16'($urandom_range(16'hFFFF)), hy});
    apb_write(REG_HIP_LEN, {16'($urandom_range(16'hFFFF)), hl});
    apb_write(REG_THIGH_LEN, {16'($urandom_range(16'hFFFF)), tl});
    apb_write(REG_CALF_LEN, {16'($urandom_range(16'hFFFF)), cl});
    @(posedge clk);
  endtask

  initial begin
    board = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Phase 1: reset lengths, slow sender and stalling receiver.
    send_idle_pct = 26;
    recv_idle_pct = 73;
    for (int leg = 0; leg < 4; leg++) begin
      send_leg(2'(leg), 16'h0000, 16'h0000, 16'h0000);
    end
    send_leg(2'd0, 16'h8000, 16'h8000, 16'h8000);
    send_leg(2'd1, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_leg(2'd2, 16'hFFFF, 16'h0001, 16'hFFFF);
    send_leg(2'd3, 16'h4000, 16'hC000, 16'h4000);
    send_leg(2'd1, 16'hC000, 16'h4000, 16'h4000);   // thigh plus calf makes a half turn
    send_leg(2'd0, 16'h3FFF, 16'h2000, 16'hE000);
    send_leg(2'd3, 16'h2000, 16'h6000, 16'h7FFF);
    send_leg(2'd2, 16'hAAAA, 16'h5555, 16'hAAAA);
    send_leg(2'd1, 16'h5555, 16'hAAAA, 16'h5555);
    send_random(90);
    drain();

    // Longest links, so linear rows clip; spare indexes and offsets must not matter.
    load_links(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    apb_write(REG_SPARE_LO, $urandom);
    apb_write(REG_SPARE_HI, $urandom);
    @(posedge clk);

    // Phase 2: roles swapped; stop once mid-phase until every column is home.
    send_idle_pct = 73;
    recv_idle_pct = 26;
    send_leg(2'd1, 16'h0000, 16'h0000, 16'h0000);
    send_leg(2'd0, 16'h4000, 16'h0000, 16'h0000);
    send_leg(2'd3, 16'h0000, 16'h4000, 16'hC000);
    send_random(57);
    drain();
    send_random(60);
    drain();

    // Zero lengths: every linear row collapses to zero.
    load_links(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(20);
    drain();

    // Phase 3: random lengths, no idling on either side.
    load_links(16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
               16'($urandom_range(20000)), 16'($urandom_range(20000)),
               16'($urandom_range(20000)));
    send_random(65);
    drain();
    load_links(16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
               16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
               16'($urandom_range(16'hFFFF)));
    send_random(65);
    drain();

    if (board.mismatches == 0 && board.owed_cols.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
